// ===== rtl/atms_pkg.sv =====
// Package for the alarm table match block with snooze.
// Holds entry and request types, operation and register codes, time constants.
// No dependencies.
`default_nettype none

package atms_pkg;

  localparam int MAX_ALARMS_DEF = 8;
  localparam int ENTRY_SLOTS    = 8;

  localparam logic [11:0] MIN_PER_DAY = 12'd1440;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_MINUTES = 2'd1;

  localparam logic [3:0]  ALARM_COUNT_RST    = 4'd0;
  localparam logic [10:0] SNOOZE_MINUTES_RST = 11'd5;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_SNOOZE = 2'd1,
    FN_CANCEL = 2'd2,
    FN_WRITE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HMUL,
    ST_MADD,
    ST_DISP,
    ST_SNZ_ADD,
    ST_SNZ_RED,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       enabled;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
  } entry_t;

  typedef struct packed {
    logic       en;
    logic [2:0] idx;
    entry_t     entry;
  } wr_req_t;

  typedef struct packed {
    logic       en;
    logic [2:0] idx;
  } dis_req_t;

endpackage

`default_nettype wire

// ===== rtl/alarm_table_match_with_snooze.sv =====
// Top level of the alarm table match block with snooze: sequencer and state.
// Uses atms_pkg, atms_alu and atms_table.
//
// Channels: in_ takes one word per item (func in in_tuser, the rest in
// in_tdata); out_ returns exactly one word per item; cfg_ writes
// alarm_count (index 0) or snooze_minutes (index 1) and is always ready.
// Sequence: an item is taken only in idle. Every item forms the minute
// of day on the shared adder (HMUL, then MADD) and then dispatches;
// a tick, unless a snooze is pending or this minute already rang,
// then scans one table entry per cycle (up to min(alarm_count,
// MAX_ALARMS, 8) entries, plus one more step to close a scan that
// misses), a snooze spends 1 add plus up to 3 modulo passes on the
// same adder. The DONE state then loads the output register; the next
// item is taken the cycle after the result is loaded.
// Reset clears the enable bit of every entry, the snooze, the guard,
// the owner index and the registers (alarm_count 0, snooze_minutes 5).
// When the receiver stalls, the result holds in the output register and
// the block finishes its next item only once that word is taken.
`default_nettype none

module alarm_table_match_with_snooze #(
  parameter int MAX_ALARMS = atms_pkg::MAX_ALARMS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [4:0] hour, [10:5] minute, [13:11] weekday, [16:14] entry_index,
  // [17] entry_enabled, [22:18] entry_hour, [28:23] entry_minute,
  // [35:29] entry_days, [39:36] zero
  input  wire logic [39:0]                   in_tdata,
  // [1:0] func
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] ring, [3:1] ring_index, [4] from_snooze, [7:5] zero
  output logic      [7:0]                    out_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [atms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [10:0]                   cfg_data
);

  import atms_pkg::*;

  localparam int TBL_DEPTH = (MAX_ALARMS < ENTRY_SLOTS) ? MAX_ALARMS : ENTRY_SLOTS;
  localparam int TBL_IW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam logic [3:0] TBL_DEPTH_W = 4'(TBL_DEPTH);

  state_t state_r, state_nxt;

  logic [3:0]  alarm_count_r;
  logic [10:0] snooze_min_r;

  func_t       func_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [2:0]  wday_r;
  logic [2:0]  wr_idx_r;
  entry_t      wr_entry_r;

  logic [11:0] acc_r, acc_nxt;
  logic [10:0] mod_r, mod_nxt;
  logic [3:0]  scan_i_r, scan_i_nxt;
  logic        ring_r, ring_nxt;
  logic        from_snz_r, from_snz_nxt;

  logic [10:0] last_min_r, last_min_nxt;
  logic        last_vld_r, last_vld_nxt;
  logic [10:0] snz_tgt_r, snz_tgt_nxt;
  logic        snz_act_r, snz_act_nxt;
  logic [2:0]  owner_r, owner_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic [11:0] alu_a, alu_b, alu_y;
  logic        alu_sub, alu_c;

  wr_req_t     wr_req;
  dis_req_t    dis_req;
  entry_t      rd_entry;
  logic [3:0]  scan_n;
  logic        hit;
  logic        in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign scan_n = (alarm_count_r < TBL_DEPTH_W) ? alarm_count_r : TBL_DEPTH_W;

  atms_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .y     (alu_y),
    .carry (alu_c)
  );

  atms_table #(
    .DEPTH (TBL_DEPTH),
    .IW    (TBL_IW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr_req),
    .dis      (dis_req),
    .rd_idx   (scan_i_r[TBL_IW-1:0]),
    .rd_entry (rd_entry)
  );

  logic [6:0] day_sel;
  assign day_sel = rd_entry.days >> wday_r;
  assign hit = rd_entry.enabled && rd_entry.hour == hour_r && rd_entry.minute == minute_r
               && (rd_entry.days == 7'd0 || day_sel[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_count_r <= ALARM_COUNT_RST;
      snooze_min_r  <= SNOOZE_MINUTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALARM_COUNT:    alarm_count_r <= cfg_data[3:0];
        CFG_SNOOZE_MINUTES: snooze_min_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= func_t'(in_tuser);
      hour_r     <= in_tdata[4:0];
      minute_r   <= in_tdata[10:5];
      wday_r     <= in_tdata[13:11];
      wr_idx_r   <= in_tdata[16:14];
      wr_entry_r <= {in_tdata[17], in_tdata[22:18], in_tdata[28:23], in_tdata[35:29]};
    end
    acc_r      <= acc_nxt;
    mod_r      <= mod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_i_r   <= 4'd0;
      ring_r     <= 1'b0;
      from_snz_r <= 1'b0;
      last_min_r <= 11'd0;
      last_vld_r <= 1'b0;
      snz_tgt_r  <= 11'd0;
      snz_act_r  <= 1'b0;
      owner_r    <= 3'd0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_i_r   <= scan_i_nxt;
      ring_r     <= ring_nxt;
      from_snz_r <= from_snz_nxt;
      last_min_r <= last_min_nxt;
      last_vld_r <= last_vld_nxt;
      snz_tgt_r  <= snz_tgt_nxt;
      snz_act_r  <= snz_act_nxt;
      owner_r    <= owner_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    mod_nxt      = mod_r;
    scan_i_nxt   = scan_i_r;
    ring_nxt     = ring_r;
    from_snz_nxt = from_snz_r;
    last_min_nxt = last_min_r;
    last_vld_nxt = last_vld_r;
    snz_tgt_nxt  = snz_tgt_r;
    snz_act_nxt  = snz_act_r;
    owner_nxt    = owner_r;
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    alu_a        = acc_r;
    alu_b        = MIN_PER_DAY;
    alu_sub      = 1'b1;
    wr_req       = '{en: 1'b0, idx: wr_idx_r, entry: wr_entry_r};
    dis_req      = '{en: 1'b0, idx: scan_i_r[2:0]};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ring_nxt     = 1'b0;
          from_snz_nxt = 1'b0;
          state_nxt    = ST_HMUL;
        end
      end
      ST_HMUL: begin
        alu_a     = {1'b0, hour_r, 6'd0};
        alu_b     = {5'd0, hour_r, 2'd0};
        alu_sub   = 1'b1;
        acc_nxt   = alu_y;
        state_nxt = ST_MADD;
      end
      ST_MADD: begin
        alu_a     = acc_r;
        alu_b     = {6'd0, minute_r};
        alu_sub   = 1'b0;
        mod_nxt   = alu_y[10:0];
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        state_nxt = ST_DONE;
        unique case (func_r)
          FN_TICK: begin
            if (snz_act_r) begin
              if (mod_r == snz_tgt_r) begin
                snz_act_nxt  = 1'b0;
                last_min_nxt = mod_r;
                last_vld_nxt = 1'b1;
                ring_nxt     = 1'b1;
                from_snz_nxt = 1'b1;
              end
            end else if (!(last_vld_r && mod_r == last_min_r)) begin
              scan_i_nxt = 4'd0;
              state_nxt  = ST_SCAN;
            end
          end
          FN_SNOOZE: state_nxt = ST_SNZ_ADD;
          FN_CANCEL: snz_act_nxt = 1'b0;
          FN_WRITE:  wr_req.en = ({1'b0, wr_idx_r} < TBL_DEPTH_W);
          default: ;
        endcase
      end
      ST_SNZ_ADD: begin
        alu_a     = {1'b0, mod_r};
        alu_b     = {1'b0, snooze_min_r};
        alu_sub   = 1'b0;
        acc_nxt   = alu_y;
        state_nxt = ST_SNZ_RED;
      end
      ST_SNZ_RED: begin
        alu_a   = acc_r;
        alu_b   = MIN_PER_DAY;
        alu_sub = 1'b1;
        if (alu_c) begin
          acc_nxt = alu_y;
        end else begin
          snz_tgt_nxt = acc_r[10:0];
          snz_act_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_i_r >= scan_n) begin
          state_nxt = ST_DONE;
        end else if (hit) begin
          last_min_nxt = mod_r;
          last_vld_nxt = 1'b1;
          owner_nxt    = scan_i_r[2:0];
          dis_req.en   = (rd_entry.days == 7'd0);
          ring_nxt     = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          scan_i_nxt = scan_i_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {3'd0, from_snz_r, owner_r, ring_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_snz_implies_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && !out_tdata[0]))
    else $error("from_snooze without ring");

  a_snz_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, snz_tgt_r} < MIN_PER_DAY)
    else $error("snooze target out of day range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again before item finished");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_i_r <= TBL_DEPTH_W)
    else $error("scan index past table depth");

endmodule

`default_nettype wire

// ===== rtl/atms_alu.sv =====
// Shared 12-bit add/subtract unit of the alarm block.
// Reports carry out, which for a subtract means a >= b. Uses atms_pkg nothing.
`default_nettype none

module atms_alu (
  input  wire logic [11:0] a,
  input  wire logic [11:0] b,
  input  wire logic        sub,
  output logic      [11:0] y,
  output logic             carry
);

  logic [12:0] sum;

  assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {12'd0, sub};
  assign y     = sum[11:0];
  assign carry = sum[12];

endmodule

`default_nettype wire

// ===== rtl/atms_table.sv =====
// Alarm entry table: one write port, one disable port, one read port.
// Enable bits clear at reset; other fields are payload. Depends on atms_pkg.
`default_nettype none

module atms_table #(
  parameter int DEPTH = atms_pkg::ENTRY_SLOTS,
  parameter int IW    = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire atms_pkg::wr_req_t  wr,
  input  wire atms_pkg::dis_req_t dis,
  input  wire logic [IW-1:0]     rd_idx,
  output atms_pkg::entry_t        rd_entry
);

  import atms_pkg::*;

  entry_t tbl_r [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!rst_n) begin
        tbl_r[i].enabled <= 1'b0;
      end else if (wr.en && wr.idx[IW-1:0] == IW'(i)) begin
        tbl_r[i] <= wr.entry;
      end else if (dis.en && dis.idx[IW-1:0] == IW'(i)) begin
        tbl_r[i].enabled <= 1'b0;
      end
    end
  end

  assign rd_entry = tbl_r[rd_idx];

endmodule

`default_nettype wire
